/* rtl/hdlt_pkg.sv */
// Shared constants and types for the head/length/tail deframer.
`default_nettype none
package hdlt_pkg;

  // Default store depth in bytes
  localparam int STORE_DEPTH_DEF = 64;

  // Frame layout: head, four ID bytes, type, four length bytes, payload, tail
  localparam int HDR_BYTES = 11;
  localparam int LEN_OFS   = 6;
  localparam int TAIL_OFS  = 10;

  // Configuration register indexes
  localparam int          REG_IDX_W = 2;
  localparam logic [1:0]  REG_HEAD  = 2'd0;
  localparam logic [1:0]  REG_TAIL  = 2'd1;
  localparam logic [1:0]  REG_MAXP  = 2'd2;

  // Reset value of the payload limit: default depth minus fifteen
  localparam logic [5:0]  MAX_PAYLOAD_RST = 6'(STORE_DEPTH_DEF - 15);

  // Store port strobes from the scan control
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

endpackage
`default_nettype wire

/* rtl/hdlt_store.sv */
// Pending byte store: one write port, one read port, registered read data.
`default_nettype none
module hdlt_store #(
  parameter int STORE_DEPTH = hdlt_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic               clk,
  input  wire hdlt_pkg::store_ctl_t ctl,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [7:0]         wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [7:0]         rdata
);

  logic [7:0] mem [STORE_DEPTH];

  // Write incoming bytes
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold data when idle
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/hdlt_ctrl.sv */
// Scan sequencer: appends bytes, checks head, length and tail, emits frames.
`default_nettype none
module hdlt_ctrl #(
  parameter int STORE_DEPTH = hdlt_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         head_marker,
  input  wire logic [7:0]         tail_marker,
  input  wire logic [5:0]         max_payload,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_frame_byte,
  output logic                    out_frame_end,
  output hdlt_pkg::store_ctl_t    st_ctl,
  output logic [AW-1:0]           st_waddr,
  output logic [7:0]              st_wdata,
  output logic [AW-1:0]           st_raddr,
  input  wire logic [7:0]         st_rdata
);

  localparam int CW        = AW + 1;
  localparam int LEN_LIMIT = STORE_DEPTH - hdlt_pkg::HDR_BYTES;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_RD,
    ST_HEAD_EV,
    ST_LEN_RD,
    ST_LEN_EV,
    ST_TAIL_RD,
    ST_TAIL_EV,
    ST_EMIT_RD,
    ST_EMIT_EV
  } state_t;

  state_t        state_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] count_r;
  logic [1:0]    lidx_r;
  logic [AW-1:0] len_r;
  logic [AW-1:0] rem_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_end_r;

  logic          accept;
  logic [CW-1:0] rd_ofs;
  logic [AW-1:0] base_inc;
  logic          out_free;
  logic          emit_go;
  logic [8:0]    tail_pos;

  // Circular address: base plus offset, folded once into the store
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [CW-1:0] sum;
    sum = {1'b0, base} + ofs;
    if (sum >= CW'(STORE_DEPTH)) begin
      sum = sum - CW'(STORE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready       = (state_r == ST_IDLE);
  assign accept         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;
  assign out_free       = !out_valid_r || out_ready;
  assign emit_go        = (state_r == ST_EMIT_EV) && out_free;
  assign base_inc       = (base_r == AW'(STORE_DEPTH - 1)) ? '0 : base_r + 1'b1;
  assign tail_pos       = {1'b0, st_rdata} + 9'(hdlt_pkg::TAIL_OFS);

  // Append the accepted byte behind the pending bytes
  assign st_ctl.we = accept;
  assign st_waddr  = wrap(base_r, count_r);
  assign st_wdata  = in_rx_byte;

  // Select the read offset for each read state
  always_comb begin
    unique case (state_r)
      ST_LEN_RD:  rd_ofs = CW'(hdlt_pkg::LEN_OFS) + CW'(lidx_r);
      ST_TAIL_RD: rd_ofs = CW'(hdlt_pkg::TAIL_OFS) + CW'(len_r);
      default:    rd_ofs = '0;
    endcase
  end

  assign st_ctl.re = (state_r == ST_HEAD_RD) || (state_r == ST_LEN_RD) ||
                     (state_r == ST_TAIL_RD) || (state_r == ST_EMIT_RD);
  assign st_raddr  = wrap(base_r, rd_ofs);

  // Sequencer, pointers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      count_r     <= '0;
      lidx_r      <= '0;
      len_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new output beat, or drop the current one once taken
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            count_r <= count_r + 1'b1;
            state_r <= ST_HEAD_RD;
          end
        end
        ST_HEAD_RD: begin
          state_r <= ST_HEAD_EV;
        end
        ST_HEAD_EV: begin
          if (st_rdata != head_marker) begin
            // drop a byte that starts no frame
            base_r  <= base_inc;
            count_r <= count_r - 1'b1;
            state_r <= (count_r == CW'(1)) ? ST_IDLE : ST_HEAD_RD;
          end else if (count_r < CW'(hdlt_pkg::HDR_BYTES)) begin
            // header not complete yet: hold pending
            state_r <= ST_IDLE;
          end else begin
            lidx_r  <= '0;
            state_r <= ST_LEN_RD;
          end
        end
        ST_LEN_RD: begin
          state_r <= ST_LEN_EV;
        end
        ST_LEN_EV: begin
          if (lidx_r != 2'd3) begin
            if (st_rdata != 8'd0) begin
              base_r  <= base_inc;
              count_r <= count_r - 1'b1;
              state_r <= ST_HEAD_RD;
            end else begin
              lidx_r  <= lidx_r + 1'b1;
              state_r <= ST_LEN_RD;
            end
          end else if (st_rdata > {2'b00, max_payload} ||
                       st_rdata > 8'(LEN_LIMIT)) begin
            // reject the length, resume after this head
            base_r  <= base_inc;
            count_r <= count_r - 1'b1;
            state_r <= ST_HEAD_RD;
          end else begin
            len_r <= st_rdata[AW-1:0];
            // tail not received yet: hold pending
            state_r <= (9'(count_r) <= tail_pos) ? ST_IDLE : ST_TAIL_RD;
          end
        end
        ST_TAIL_RD: begin
          state_r <= ST_TAIL_EV;
        end
        ST_TAIL_EV: begin
          if (st_rdata != tail_marker) begin
            base_r  <= base_inc;
            count_r <= count_r - 1'b1;
            state_r <= ST_HEAD_RD;
          end else begin
            rem_r   <= AW'(hdlt_pkg::TAIL_OFS) + len_r;
            state_r <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_EV;
        end
        ST_EMIT_EV: begin
          // advance when the output register is free
          if (out_free) begin
            out_byte_r  <= st_rdata;
            out_end_r   <= (rem_r == '0);
            base_r      <= base_inc;
            count_r     <= count_r - 1'b1;
            if (rem_r == '0) begin
              state_r <= (count_r == CW'(1)) ? ST_IDLE : ST_HEAD_RD;
            end else begin
              rem_r   <= rem_r - 1'b1;
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/head_length_tail_deframer.sv */
// Each accepted byte starts a scan: the oldest pending byte is read and checked
// against the head marker; a complete header is then verified by four length
// reads and a tail read. A new input byte is taken only while idle, after the
// scan of the last one; each emitted byte is a store read and waits on out_ready.
// Reset (rst_n low, synchronous) empties the store pointers, drops any output
// beat and loads register defaults; the store contents are not cleared.
`default_nettype none
module head_length_tail_deframer #(
  parameter int STORE_DEPTH = hdlt_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hdlt_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_frame_byte,
  output logic                                out_frame_end
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [7:0]           head_r;
  logic [7:0]           tail_r;
  logic [5:0]           maxp_r;
  hdlt_pkg::store_ctl_t st_ctl;
  logic [AW-1:0]        st_waddr;
  logic [7:0]           st_wdata;
  logic [AW-1:0]        st_raddr;
  logic [7:0]           st_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 8'd0;
      tail_r <= 8'd0;
      maxp_r <= hdlt_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hdlt_pkg::REG_HEAD: head_r <= cfg_data;
        hdlt_pkg::REG_TAIL: tail_r <= cfg_data;
        hdlt_pkg::REG_MAXP: maxp_r <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  hdlt_ctrl #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_marker   (head_r),
    .tail_marker   (tail_r),
    .max_payload   (maxp_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_frame_end (out_frame_end),
    .st_ctl        (st_ctl),
    .st_waddr      (st_waddr),
    .st_wdata      (st_wdata),
    .st_raddr      (st_raddr),
    .st_rdata      (st_rdata)
  );

  hdlt_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk  (clk),
    .ctl  (st_ctl),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

endmodule
`default_nettype wire

/* rtl/hdlt_checker.sv */
// Port-level checks for the deframer, bound to the top level.
`default_nettype none
module hdlt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_frame_end
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) &&
                                $stable(out_frame_end))
    else $error("stalled output beat changed");

  // Scan an accepted byte before taking the next one
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before scan");

  // Drop any output beat on reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind head_length_tail_deframer hdlt_checker u_hdlt_checker (.*);
`default_nettype wire

/* bench/head_length_tail_deframer_tb.sv */
// Self-checking bench for the deframer: random framed byte streams, own predictor.
`timescale 1ns / 1ps
module head_length_tail_deframer_tb;

  localparam int DEPTH         = hdlt_pkg::STORE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 2000;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef struct {
    logic [7:0] fbyte;
    logic       fend;
  } frame_beat_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index      = hdlt_pkg::REG_HEAD;
  logic [7:0] cfg_data       = 8'h00;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte     = 8'h00;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_frame_end;

  head_length_tail_deframer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor state: register copies and the pending byte store
  logic [7:0]  head_reg  = 8'h00;
  logic [7:0]  tail_reg  = 8'h00;
  logic [5:0]  maxp_reg  = hdlt_pkg::MAX_PAYLOAD_RST;
  logic [7:0]  pend_store [DEPTH];
  int          pend_cnt  = 0;

  frame_beat_t frame_beats_q [$];
  logic [7:0]  rx_bytes_q [$];
  int          gen_count = 0;
  int          errors    = 0;
  int          cycles    = 0;

  // Append one received byte, rescan the store and queue every completed frame
  function automatic void deframe_byte(input logic [7:0] b);
    int          i;
    int          keep;
    int          tail;
    int          n;
    int          k;
    int          rest;
    logic [31:0] len;
    frame_beat_t beat;
    if (pend_cnt < DEPTH) begin
      pend_store[pend_cnt] = b;
      pend_cnt++;
    end
    keep = pend_cnt;
    i = 0;
    n = 0;
    while (i < pend_cnt) begin
      if (pend_store[i] != head_reg) begin
        i++;
        continue;
      end
      if (i + hdlt_pkg::HDR_BYTES > pend_cnt) begin
        keep = i;
        break;
      end
      len = {pend_store[i+hdlt_pkg::LEN_OFS], pend_store[i+hdlt_pkg::LEN_OFS+1],
             pend_store[i+hdlt_pkg::LEN_OFS+2], pend_store[i+hdlt_pkg::LEN_OFS+3]};
      // drop heads with a negative, oversized or unstorable length
      if (len[31] || len > 32'(maxp_reg) || len + hdlt_pkg::HDR_BYTES > DEPTH) begin
        i++;
        continue;
      end
      tail = i + hdlt_pkg::TAIL_OFS + int'(len);
      if (tail >= pend_cnt) begin
        keep = i;
        break;
      end
      if (pend_store[tail] != tail_reg) begin
        i++;
        continue;
      end
      for (k = i; k <= tail; k++) begin
        if (n < DEPTH) begin
          beat.fbyte = pend_store[k];
          beat.fend  = (k == tail);
          frame_beats_q.push_back(beat);
          n++;
        end
      end
      i = tail + 1;
    end
    // keep only the bytes from the first incomplete frame on
    if (keep < pend_cnt) begin
      rest = pend_cnt - keep;
      for (k = 0; k < rest; k++) pend_store[k] = pend_store[keep + k];
      pend_cnt = rest;
    end else begin
      pend_cnt = 0;
    end
  endfunction

  // Input driver: launch queued bytes, predict on each accepted beat
  int   drv_gap   = 0;
  logic drv_quiet = 1'b0;

  always @(posedge clk) begin : drv
    logic       nv;
    logic [7:0] nb;
    nv = in_valid;
    nb = in_rx_byte;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        nv = 1'b0;
      end
      if (!nv) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (rx_bytes_q.size() > 0) begin
          nb = rx_bytes_q.pop_front();
          nv = 1'b1;
          drv_gap = drv_quiet ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 47) == 0) drv_quiet = !drv_quiet;
        end
      end
    end
    in_valid   <= nv;
    in_rx_byte <= nb;
  end

  // Output monitor: check each beat against the oldest expected frame byte
  int   mon_stall = 0;
  logic mon_quiet = 1'b0;

  always @(posedge clk) begin : mon
    logic        nr;
    frame_beat_t want;
    nr = out_ready;
    if (!rst_n) begin
      nr = 1'b1;
    end else if (out_valid && out_ready) begin
      if (frame_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, got byte %02h end %0b",
                 $time, out_frame_byte, out_frame_end);
        errors++;
      end else begin
        want = frame_beats_q.pop_front();
        if (out_frame_byte !== want.fbyte) begin
          $display("%0t: frame_byte mismatch, expected %02h, got %02h",
                   $time, want.fbyte, out_frame_byte);
          errors++;
        end
        if (out_frame_end !== want.fend) begin
          $display("%0t: frame_end mismatch, expected %0b, got %0b",
                   $time, want.fend, out_frame_end);
          errors++;
        end
      end
      mon_stall = mon_quiet ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 47) == 0) mon_quiet = !mon_quiet;
      nr = (mon_stall == 0);
    end else if (!out_ready) begin
      if (mon_stall > 0) mon_stall--;
      if (mon_stall == 0) nr = 1'b1;
    end
    out_ready <= nr;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycles, frame_beats_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Write one register and mirror it into the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hdlt_pkg::REG_HEAD: head_reg = val;
      hdlt_pkg::REG_TAIL: tail_reg = val;
      hdlt_pkg::REG_MAXP: maxp_reg = val[5:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] h, input logic [7:0] t, input int m);
    write_reg(hdlt_pkg::REG_HEAD, h);
    write_reg(hdlt_pkg::REG_TAIL, t);
    write_reg(hdlt_pkg::REG_MAXP, 8'(m));
  endtask

  // Hold until every byte is in and every beat is out, then let the scan settle
  task automatic wait_idle();
    do @(posedge clk);
    while (rx_bytes_q.size() != 0 || in_valid || frame_beats_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_rx(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    gen_count++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_rx(8'($urandom));
  endtask

  // Head, four ID bytes, type byte and big-endian length
  task automatic push_head(input logic [31:0] len);
    push_rx(head_reg);
    push_random(5);
    push_rx(len[31:24]);
    push_rx(len[23:16]);
    push_rx(len[15:8]);
    push_rx(len[7:0]);
  endtask

  task automatic push_good(input int len);
    push_head(32'(len));
    push_random(len);
    push_rx(tail_reg);
  endtask

  task automatic push_bad_tail(input int len);
    push_head(32'(len));
    push_random(len);
    push_rx(tail_reg ^ 8'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic gen_stream(input int n);
    int          start;
    int          r;
    int          len;
    logic [31:0] big;
    start = gen_count;
    while (gen_count - start < n) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) len = $urandom_range(0, maxp_reg);
      else len = $urandom_range(0, (maxp_reg < 6) ? maxp_reg : 6);
      if (r < 55) begin
        push_good(len);
      end else if (r < 65) begin
        push_bad_tail(len);
      end else if (r < 73) begin
        // length above the limit
        if ($urandom_range(0, 1) == 0) big = 32'($urandom_range(maxp_reg + 1, 63));
        else big = ({1'b0, 31'($urandom)} | 32'h100);
        push_head(big);
        push_random($urandom_range(0, 4));
      end else if (r < 78) begin
        push_head({1'b1, 31'($urandom)});
        push_random($urandom_range(0, 4));
      end else if (r < 88) begin
        push_random($urandom_range(1, 4));
      end else begin
        // frame cut short, later bytes resolve it
        push_rx(head_reg);
        push_random($urandom_range(0, 9));
      end
    end
  endtask

  // Stimulus
  initial begin : main
    int p;
    for (int k = 0; k < DEPTH; k++) pend_store[k] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero markers, payload limit of 49
    gen_stream(40);
    wait_idle();

    // directed frames
    set_markers(8'hA5, 8'h5A, 49);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_good(0);
    push_good(49);
    push_head(32'd50);
    push_random(3);
    push_head(32'h8000_0000);
    push_random(2);
    push_bad_tail(1);
    // outer frame with a bad tail hides two good frames; both come out on its tail
    push_head(32'd24);
    push_good(0);
    push_good(0);
    push_rx(8'h00);
    push_rx(8'h11);
    push_rx(8'hFF);
    push_good(3);
    wait_idle();

    // random phases across register settings
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_markers(8'hFF, 8'h00, 0);
        1: set_markers(8'h00, 8'hFF, 49);
        2: set_markers(8'h7E, 8'h7E, $urandom_range(0, 49));
        default: set_markers(8'($urandom), 8'($urandom), $urandom_range(0, 49));
      endcase
      gen_stream(50);
      wait_idle();
    end

    if (errors == 0 && frame_beats_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
